>>> hw/rtl/vn_pkg.sv
package vn_pkg;

    // Field widths.
    localparam int CW = 16;             // input component width
    localparam int F  = 14;             // fraction bits of a unit component
    localparam int UW = F + 2;          // unit component width
    localparam int QW = F + 1;          // unit magnitude, up to 2^F
    localparam int LW = 2 * CW;         // squared length width
    localparam int MW = CW + 1;         // component magnitude width
    localparam int SQW = 2 * CW - 1;    // squared magnitude width
    localparam int AW = 2 * CW + 2 * F + 4;  // running product width
    localparam int BW = LW + F + 3;     // signed cross term width
    localparam int SW = $clog2(F + 1);  // bit position width
    localparam int NL = 3;              // vector lanes

    // One component while its unit magnitude is resolved bit by bit.
    // a holds (2q-1)^2 * len, b holds (2q-1) * len, r holds mag^2 * 2^(2F+2).
    typedef struct packed {
        logic          neg;
        logic [QW-1:0] q;
        logic [AW-1:0] r;
        logic [AW-1:0] a;
        logic [BW-1:0] b;
    } lane_t;

    typedef struct packed {
        logic               zero;
        logic [LW-1:0]      len;
        lane_t [NL-1:0]     lane;
    } item_t;

endpackage

>>> hw/rtl/vn_prep.sv
module vn_prep import vn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [NL-1:0][CW-1:0] in_comp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output item_t                out_data
);

    logic                   v1_reg, v2_reg, v3_reg;
    logic [NL-1:0][MW-1:0]  mag_reg;
    logic [NL-1:0]          neg1_reg, neg2_reg;
    logic                   zero1_reg, zero2_reg;
    logic [NL-1:0][SQW-1:0] sq_reg;
    item_t                  item_reg;
    item_t                  item_next;
    logic                   r1, r2, r3;

    // Each stage moves when it is empty or its successor moves.
    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // Stage one: magnitudes and signs.
    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            for (int i = 0; i < NL; i++) begin
                neg1_reg[i] <= in_comp[i][CW-1];
                if (in_comp[i][CW-1]) begin
                    mag_reg[i] <= {1'b0, ~in_comp[i]} + MW'(1);
                end else begin
                    mag_reg[i] <= {1'b0, in_comp[i]};
                end
            end
            zero1_reg <= (in_comp == '0);
        end
    end

    // Stage two: squares.
    always_ff @(posedge aclk) begin
        if (r2 && v1_reg) begin
            for (int i = 0; i < NL; i++) begin
                sq_reg[i] <= SQW'(mag_reg[i]) * SQW'(mag_reg[i]);
            end
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // Stage three: length and the starting point of the search.
    always_comb begin
        item_next      = '0;
        item_next.zero = zero2_reg;
        item_next.len  = LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]);
        for (int i = 0; i < NL; i++) begin
            item_next.lane[i].neg = neg2_reg[i];
            item_next.lane[i].q   = '0;
            item_next.lane[i].r   = AW'(sq_reg[i]) << (2 * F + 2);
            item_next.lane[i].a   = AW'(item_next.len);
            item_next.lane[i].b   = BW'(0) - BW'(item_next.len);
        end
    end

    always_ff @(posedge aclk) begin
        if (r3 && v2_reg) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = item_reg;

endmodule

>>> hw/rtl/vn_step.sv
module vn_step import vn_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [SW-1:0] bit_idx,
    input  logic          in_valid,
    output logic          in_ready,
    input  item_t         in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output item_t         out_data
);

    logic  valid_reg;
    item_t data_reg;
    item_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // Try setting one bit of each unit magnitude. The trial square is built
    // from the stored terms with shifts and adds only.
    always_comb begin
        logic [AW-1:0] len_ext;
        logic [AW-1:0] b_ext;
        logic [AW-1:0] a_try;
        logic          skip;
        data_next = in_data;
        len_ext   = AW'(in_data.len);
        for (int i = 0; i < NL; i++) begin
            b_ext = AW'($signed(in_data.lane[i].b));
            a_try = in_data.lane[i].a + (b_ext << ({2'b0, bit_idx} + 2))
                  + (len_ext << ({1'b0, bit_idx, 1'b0} + 2));
            skip  = (bit_idx != SW'(F)) && in_data.lane[i].q[F];
            if (!skip && (a_try <= in_data.lane[i].r)) begin
                data_next.lane[i].a = a_try;
                data_next.lane[i].b = in_data.lane[i].b
                                    + (BW'(in_data.len) << ({1'b0, bit_idx} + 1));
                data_next.lane[i].q = in_data.lane[i].q | (QW'(1) << bit_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/vn_out.sv
module vn_out import vn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  item_t                 in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NL-1:0][UW-1:0] out_unit,
    output logic [LW-1:0]         out_len,
    output logic                  out_zero
);

    logic                  valid_reg;
    logic [NL-1:0][UW-1:0] unit_reg, unit_next;
    logic [LW-1:0]         len_reg;
    logic                  zero_reg;

    assign in_ready = !valid_reg || out_ready;

    // Apply the sign; a zero vector gives zero components.
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (in_data.zero) begin
                unit_next[i] = '0;
            end else if (in_data.lane[i].neg) begin
                unit_next[i] = UW'(0) - UW'(in_data.lane[i].q);
            end else begin
                unit_next[i] = UW'(in_data.lane[i].q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            unit_reg <= unit_next;
            len_reg  <= in_data.len;
            zero_reg <= in_data.zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign out_len   = len_reg;
    assign out_zero  = zero_reg;

endmodule

>>> hw/rtl/vector3_normalize_core.sv
// Vector normalization core.
// The input channel (s_valid, s_ready) takes one vector of three signed
// components per beat. The result channel (m_valid, m_ready) returns, per
// beat, the unit vector in Q1.14 (16384 is 1.0), rounded to nearest with
// ties away from zero, the squared length, and a flag for a zero vector,
// whose unit components are then zero.
// Three stages form magnitudes, squares and the length, fifteen stages
// each resolve one bit of the unit magnitudes of all three components,
// and one stage applies the signs. Throughput is one vector per cycle
// while the receiver does not stall; every stage is a registered slice
// with its own valid bit.
// When the receiver stalls, the stages fill from the output backward and
// bubbles are squeezed out; s_ready falls only once every stage holds a
// vector. No beat is lost or repeated.
// A synchronous reset (aresetn low) empties all stages.
module vector3_normalize_core import vn_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [CW-1:0] s_x_in,
    input  logic [CW-1:0] s_y_in,
    input  logic [CW-1:0] s_z_in,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [UW-1:0] m_x_unit,
    output logic [UW-1:0] m_y_unit,
    output logic [UW-1:0] m_z_unit,
    output logic [LW-1:0] m_length_squared,
    output logic          m_zero_vector
);

    logic                  chain_valid [F+2];
    logic                  chain_ready [F+2];
    item_t                 chain_data  [F+2];
    logic [NL-1:0][CW-1:0] comp;
    logic [NL-1:0][UW-1:0] unit;

    assign comp[0] = s_x_in;
    assign comp[1] = s_y_in;
    assign comp[2] = s_z_in;

    // Magnitudes, squares and length.
    vn_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_comp   (comp),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // One stage per bit of the unit magnitude, most significant first.
    for (genvar g = 0; g <= F; g++) begin : g_step
        vn_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .bit_idx   (SW'(F - g)),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // Signs and the output register.
    vn_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[F+1]),
        .in_ready  (chain_ready[F+1]),
        .in_data   (chain_data[F+1]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_unit  (unit),
        .out_len   (m_length_squared),
        .out_zero  (m_zero_vector)
    );

    assign m_x_unit = unit[0];
    assign m_y_unit = unit[1];
    assign m_z_unit = unit[2];

endmodule
